// ===== rtl/mmad_pkg.sv =====
// ----------------------------------------------------------------------------
// mmad_pkg
// Shared types and constants for the memory map address decoder: target
// codes, register indexes, fixed region bounds and the bundles that pass
// between the top level and the decode logic.
// ----------------------------------------------------------------------------
package mmad_pkg;

    // target codes
    localparam logic [3:0] TGT_RAM    = 4'd0;
    localparam logic [3:0] TGT_BASIC  = 4'd1;
    localparam logic [3:0] TGT_KERNEL = 4'd2;
    localparam logic [3:0] TGT_PIA    = 4'd3;
    localparam logic [3:0] TGT_FACIA  = 4'd4;
    localparam logic [3:0] TGT_SCREEN = 4'd5;
    localparam logic [3:0] TGT_COLOR  = 4'd6;
    localparam logic [3:0] TGT_HIRES  = 4'd7;
    localparam logic [3:0] TGT_ASCII  = 4'd8;
    localparam logic [3:0] TGT_POLLED = 4'd9;
    localparam logic [3:0] TGT_TAPE   = 4'd10;
    localparam logic [3:0] TGT_NONE   = 4'd11;

    // configuration register indexes
    localparam logic [2:0] REG_RAM_TOP        = 3'd0;
    localparam logic [2:0] REG_BASIC_ENABLE   = 3'd1;
    localparam logic [2:0] REG_DEVICE_ENABLES = 3'd2;
    localparam logic [2:0] REG_HIRES_SELECT   = 3'd3;
    localparam logic [2:0] REG_TAPE_BASE      = 3'd4;
    localparam logic [2:0] REG_KERN_FLOOR     = 3'd5;

    // hires select codes
    localparam logic [1:0] HIRES_NONE = 2'd0;
    localparam logic [1:0] HIRES_HIGH = 2'd1;
    localparam logic [1:0] HIRES_LOW  = 2'd2;

    // device enable bit positions
    localparam int DEV_FLOPPY = 0;
    localparam int DEV_VIDEO  = 1;
    localparam int DEV_COLOR  = 2;
    localparam int DEV_ASCII  = 3;

    // fixed region bounds
    localparam logic [15:0] RAM_TOP_MAX   = 16'hBFFF;
    localparam logic [15:0] BASIC_LO      = 16'hA000;
    localparam logic [15:0] BASIC_HI      = 16'hBFFF;
    localparam logic [15:0] PIA_LO        = 16'hC000;
    localparam logic [15:0] PIA_HI        = 16'hC003;
    localparam logic [15:0] FACIA_LO      = 16'hC010;
    localparam logic [15:0] FACIA_HI      = 16'hC011;
    localparam logic [15:0] SCREEN_LO     = 16'hD000;
    localparam logic [15:0] SCREEN_HI     = 16'hD7FF;
    localparam logic [15:0] HIGH_WIN_LO   = 16'hE000;
    localparam logic [15:0] HIGH_WIN_HI   = 16'hE7FF;
    localparam logic [15:0] LOW_HIRES_LO  = 16'h8000;
    localparam logic [15:0] LOW_HIRES_HI  = 16'h9FFF;
    localparam logic [15:0] ASCII_ADDR    = 16'hDF01;
    localparam logic [7:0]  POLLED_PAGE   = 8'hDF;
    localparam logic [15:0] KERNEL_BASE   = 16'hF000;
    localparam logic [7:0]  OPEN_BUS_BYTE = 8'hFF;

    // configuration register bundle
    typedef struct packed {
        logic [15:0] ram_top;
        logic        basic_enable;
        logic [3:0]  device_enables;
        logic [1:0]  hires_select;
        logic [15:0] tape_base;
        logic [15:0] kern_floor;
    } t_cfg;

    // decoded result item
    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] target_offset;
        logic [7:0]  forwarded_data;
        logic        write_strobe;
        logic [7:0]  open_bus_data;
    } t_result;

endpackage

// ===== rtl/mmad_decode.sv =====
// ----------------------------------------------------------------------------
// mmad_decode
// Priority decode of one bus access into target, offset and write/read
// side outputs, from the current configuration registers.
// ----------------------------------------------------------------------------
module mmad_decode (
    input  logic             i_mode,
    input  logic [15:0]      i_bus_address,
    input  logic [7:0]       i_write_data,
    input  mmad_pkg::t_cfg   i_cfg,
    output mmad_pkg::t_result o_result
);
    import mmad_pkg::*;

    logic [15:0] ram_top_eff;
    logic [15:0] kern_floor_eff;
    logic [16:0] tape_last;
    logic        wr;
    logic        floppy;
    logic        video;
    logic        color;
    logic        ascii;
    logic        tape_hit;
    logic [3:0]  target;
    logic [15:0] offset;
    logic        hit;

    // clamp the configured bounds
    assign ram_top_eff    = (i_cfg.ram_top > RAM_TOP_MAX) ? RAM_TOP_MAX : i_cfg.ram_top;
    assign kern_floor_eff = (i_cfg.kern_floor < KERNEL_BASE) ? KERNEL_BASE
                                                             : i_cfg.kern_floor;

    assign wr     = i_mode;
    assign floppy = i_cfg.device_enables[DEV_FLOPPY];
    assign video  = i_cfg.device_enables[DEV_VIDEO];
    assign color  = i_cfg.device_enables[DEV_COLOR];
    assign ascii  = i_cfg.device_enables[DEV_ASCII];

    // tape window never wraps past the top of memory
    assign tape_last = {1'b0, i_cfg.tape_base} + 17'd3;
    assign tape_hit  = (i_bus_address >= i_cfg.tape_base) &&
                       ({1'b0, i_bus_address} <= tape_last);

    // regions in priority order
    always_comb begin
        target = TGT_NONE;
        offset = '0;
        if (i_bus_address <= ram_top_eff) begin
            target = TGT_RAM;
            offset = i_bus_address;
        end else if (!wr && i_cfg.basic_enable &&
                     i_bus_address >= BASIC_LO && i_bus_address <= BASIC_HI) begin
            target = TGT_BASIC;
            offset = i_bus_address - BASIC_LO;
        end else if (floppy && i_bus_address >= PIA_LO && i_bus_address <= PIA_HI) begin
            target = TGT_PIA;
            offset = i_bus_address - PIA_LO;
        end else if (floppy && i_bus_address >= FACIA_LO && i_bus_address <= FACIA_HI) begin
            target = TGT_FACIA;
            offset = i_bus_address - FACIA_LO;
        end else if (video && i_bus_address >= SCREEN_LO && i_bus_address <= SCREEN_HI) begin
            target = TGT_SCREEN;
            offset = i_bus_address - SCREEN_LO;
        end else if (video && color &&
                     i_bus_address >= HIGH_WIN_LO && i_bus_address <= HIGH_WIN_HI) begin
            target = TGT_COLOR;
            offset = i_bus_address - HIGH_WIN_LO;
        end else if (video && i_cfg.hires_select == HIRES_HIGH &&
                     i_bus_address >= HIGH_WIN_LO && i_bus_address <= HIGH_WIN_HI) begin
            target = TGT_HIRES;
            offset = i_bus_address - HIGH_WIN_LO;
        end else if (video && i_cfg.hires_select == HIRES_LOW &&
                     i_bus_address >= LOW_HIRES_LO && i_bus_address <= LOW_HIRES_HI) begin
            target = TGT_HIRES;
            offset = i_bus_address - LOW_HIRES_LO;
        end else if (!wr && ascii && i_bus_address == ASCII_ADDR) begin
            target = TGT_ASCII;
            offset = '0;
        end else if (i_bus_address[15:8] == POLLED_PAGE) begin
            target = TGT_POLLED;
            offset = {8'h00, i_bus_address[7:0]};
        end else if (!wr && i_bus_address >= kern_floor_eff) begin
            target = TGT_KERNEL;
            offset = i_bus_address - KERNEL_BASE;
        end else if (tape_hit) begin
            target = TGT_TAPE;
            offset = i_bus_address - i_cfg.tape_base;
        end
    end

    assign hit = (target != TGT_NONE);

    // side outputs
    assign o_result.target         = target;
    assign o_result.target_offset  = offset;
    assign o_result.write_strobe   = wr && hit;
    assign o_result.forwarded_data = (wr && hit) ? i_write_data : 8'h00;
    assign o_result.open_bus_data  = (!wr && !hit) ? OPEN_BUS_BYTE : 8'h00;

endmodule

// ===== rtl/memory_map_address_decoder.sv =====
// Result path: the access is held in the input register, then decoded
// into the result register.
// Throughput: one access per cycle while m_axis_tready is not held low;
// the single-pass decode sits between the input and result registers.
// Reset: synchronous active-low; clears both valid flags and loads the
// configuration registers with their reset values.
// ----------------------------------------------------------------------------
// memory_map_address_decoder
// Stream-in, stream-out bus access decoder: picks the target of each CPU
// access by fixed priority and gives the offset within that target.
// ----------------------------------------------------------------------------
module memory_map_address_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // bus_address[15:0], write_data[23:16]
    input  logic [0:0]  s_axis_tuser,  // mode[0]
    // result item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // target_offset[15:0], forwarded_data[23:16],
                                       // open_bus_data[31:24]
    output logic [4:0]  m_axis_tuser,  // target[3:0], write_strobe[4]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mmad_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_mode;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_wdata;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        out_ready;
    logic        in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_top        <= 16'h9FFF;
            r_cfg.basic_enable   <= 1'b1;
            r_cfg.device_enables <= 4'h0;
            r_cfg.hires_select   <= HIRES_NONE;
            r_cfg.tape_base      <= 16'hF000;
            r_cfg.kern_floor     <= 16'hF000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RAM_TOP:        r_cfg.ram_top        <= i_cfg_data;
                REG_BASIC_ENABLE:   r_cfg.basic_enable   <= i_cfg_data[0];
                REG_DEVICE_ENABLES: r_cfg.device_enables <= i_cfg_data[3:0];
                REG_HIRES_SELECT:   r_cfg.hires_select   <= i_cfg_data[1:0];
                REG_TAPE_BASE:      r_cfg.tape_base      <= i_cfg_data;
                REG_KERN_FLOOR:     r_cfg.kern_floor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in_mode  <= s_axis_tuser[0];
            r_in_addr  <= s_axis_tdata[15:0];
            r_in_wdata <= s_axis_tdata[23:16];
        end
    end

    // decode
    mmad_decode u_decode (
        .i_mode        (r_in_mode),
        .i_bus_address (r_in_addr),
        .i_write_data  (r_in_wdata),
        .i_cfg         (r_cfg),
        .o_result      (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.open_bus_data, r_out.forwarded_data, r_out.target_offset};
    assign m_axis_tuser  = {r_out.write_strobe, r_out.target};

endmodule
